// File: rtl/owbm_pkg.sv
// Shared types, codes and the CRC-8 step for the one-wire bus master.
package owbm_pkg;

  localparam int TIMER_BITS_DEF = 10;
  localparam int DUR_W          = 10;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 10;

  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_RESET = 2'd1,
    REQ_WRITE = 2'd2,
    REQ_READ  = 2'd3
  } req_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RESET_LOW    = 3'd0,
    CFG_PRES_DELAY   = 3'd1,
    CFG_PRES_TAIL    = 3'd2,
    CFG_SLOT_LOW     = 3'd3,
    CFG_READ_DELAY   = 3'd4,
    CFG_SLOT_LEN     = 3'd5,
    CFG_RECOVERY     = 3'd6
  } cfg_idx_e;

  localparam logic [7:0] CRC_POLY = 8'h8C;
  localparam logic [7:0] RX_MSB   = 8'h80;

  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic       presence;
    logic [7:0] rx_byte;
    logic [7:0] crc_value;
    logic       rejected;
  } result_t;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// File: rtl/one_wire_bus_master_top.sv
// One-wire bus master top level: timing sequencer, CRC-8 and result buffering.
// Every accepted input word (a one-microsecond tick or a command) is handled in the
// cycle it arrives and yields exactly one result word, which is registered in the
// output register, or in a second result register while the output is stalled. The
// block takes one word per clock while not stalled; input stall rises only when both
// result registers are full. Bus timing is counted in tick words, not clocks.
// Configuration writes are accepted in every cycle.
module one_wire_bus_master_top
  import owbm_pkg::*;
#(
  parameter int TimerBits = TIMER_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [1:0]            req_type_i,
  input  logic [7:0]            tx_byte_i,
  input  logic                  line_level_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  drive_low_o,
  output logic                  busy_res_o,
  output logic                  done_res_o,
  output logic                  presence_o,
  output logic [7:0]            rx_byte_o,
  output logic [7:0]            crc_value_o,
  output logic                  rejected_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  typedef enum logic [3:0] {
    PH_IDLE       = 4'd0,
    PH_RECOVERY   = 4'd1,
    PH_RESET_LOW  = 4'd2,
    PH_RESET_WAIT = 4'd3,
    PH_RESET_TAIL = 4'd4,
    PH_SLOT_START = 4'd5,
    PH_WRITE_HOLD = 4'd6,
    PH_READ_WAIT  = 4'd7,
    PH_READ_REST  = 4'd8
  } phase_e;

  localparam int CmpW = (TimerBits > DUR_W) ? TimerBits : DUR_W;

  function automatic logic [TimerBits-1:0] timer_load(input logic [DUR_W-1:0] d);
    logic [CmpW-1:0] d_ext;
    logic [CmpW-1:0] top_ext;
    d_ext   = CmpW'(d);
    top_ext = CmpW'({TimerBits{1'b1}});
    if (d_ext == '0) begin
      d_ext = CmpW'(1);
    end
    if (d_ext > top_ext) begin
      d_ext = top_ext;
    end
    return d_ext[TimerBits-1:0];
  endfunction

  logic [9:0] rst_low_q;
  logic [7:0] pres_delay_q;
  logic [7:0] pres_tail_q;
  logic [3:0] slot_low_q;
  logic [5:0] read_delay_q;
  logic [6:0] slot_len_q;
  logic [7:0] recovery_q;

  phase_e               phase_q, phase_d;
  req_e                 op_q, op_d;
  logic [TimerBits-1:0] time_q, time_d, tl;
  logic [2:0]           bit_q, bit_d;
  logic [7:0]           shift_q, shift_d;
  logic                 pres_q, pres_d;
  logic [7:0]           crc_q, crc_d;
  logic                 drive_q, drive_d;
  logic [7:0]           rx_q, rx_d;

  logic       in_acc;
  logic       done;
  logic       rej;
  req_e       req;
  logic [6:0] write_rest;
  logic [6:0] read_rest;
  result_t    res;

  logic    out_valid_q, skid_valid_q;
  result_t out_q, skid_q;
  logic    out_free;

  assign req        = req_e'(req_type_i);
  assign in_acc     = in_valid_i && !skid_valid_q;
  assign in_stall_o = skid_valid_q;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign cfg_ready_o = 1'b1;

  assign write_rest = (slot_len_q > 7'(slot_low_q)) ? (slot_len_q - 7'(slot_low_q)) : '0;
  assign read_rest  = (write_rest > 7'(read_delay_q)) ? (write_rest - 7'(read_delay_q)) : '0;

  always_comb begin
    phase_d = phase_q;
    op_d    = op_q;
    time_d  = time_q;
    bit_d   = bit_q;
    shift_d = shift_q;
    pres_d  = pres_q;
    crc_d   = crc_q;
    drive_d = drive_q;
    rx_d    = rx_q;
    done    = 1'b0;
    rej     = 1'b0;
    tl      = (time_q != '0) ? (time_q - 1'b1) : '0;
    if (in_acc) begin
      if (req != REQ_TICK) begin
        if (phase_q != PH_IDLE) begin
          rej = 1'b1;
        end else begin
          op_d    = req;
          bit_d   = '0;
          if (req == REQ_RESET) begin
            crc_d = '0;
          end
          shift_d = (req == REQ_WRITE) ? tx_byte_i : '0;
          phase_d = PH_RECOVERY;
          drive_d = 1'b0;
          time_d  = timer_load(DUR_W'(recovery_q));
        end
      end else if (phase_q != PH_IDLE) begin
        time_d = tl;
        if (tl == '0) begin
          unique case (phase_q)
            PH_RECOVERY: begin
              if (op_q == REQ_RESET) begin
                phase_d = PH_RESET_LOW;
                drive_d = 1'b1;
                time_d  = timer_load(rst_low_q);
              end else begin
                phase_d = PH_SLOT_START;
                drive_d = 1'b1;
                time_d  = timer_load(DUR_W'(slot_low_q));
              end
            end
            PH_RESET_LOW: begin
              phase_d = PH_RESET_WAIT;
              drive_d = 1'b0;
              time_d  = timer_load(DUR_W'(pres_delay_q));
            end
            PH_RESET_WAIT: begin
              pres_d  = !line_level_i;
              phase_d = PH_RESET_TAIL;
              drive_d = 1'b0;
              time_d  = timer_load(DUR_W'(pres_tail_q));
            end
            PH_SLOT_START: begin
              if (op_q == REQ_WRITE) begin
                phase_d = PH_WRITE_HOLD;
                drive_d = !shift_q[0];
                time_d  = timer_load(DUR_W'(write_rest));
              end else begin
                phase_d = PH_READ_WAIT;
                drive_d = 1'b0;
                time_d  = timer_load(DUR_W'(read_delay_q));
              end
            end
            PH_READ_WAIT: begin
              shift_d = (shift_q >> 1) | (line_level_i ? RX_MSB : 8'h00);
              phase_d = PH_READ_REST;
              drive_d = 1'b0;
              time_d  = timer_load(DUR_W'(read_rest));
            end
            PH_WRITE_HOLD, PH_READ_REST: begin
              if (phase_q == PH_WRITE_HOLD) begin
                shift_d = shift_q >> 1;
              end else if (bit_q == 3'd7) begin
                rx_d  = shift_q;
                crc_d = crc8_byte(crc_q, shift_q);
              end
              if (bit_q == 3'd7) begin
                phase_d = PH_IDLE;
                drive_d = 1'b0;
                time_d  = '0;
                done    = 1'b1;
              end else begin
                bit_d   = bit_q + 3'd1;
                phase_d = PH_RECOVERY;
                drive_d = 1'b0;
                time_d  = timer_load(DUR_W'(recovery_q));
              end
            end
            PH_RESET_TAIL: begin
              phase_d = PH_IDLE;
              drive_d = 1'b0;
              time_d  = '0;
              done    = 1'b1;
            end
            default: begin
              phase_d = PH_IDLE;
              drive_d = 1'b0;
              time_d  = '0;
            end
          endcase
        end
      end
    end
  end

  always_comb begin
    res.drive_low = drive_d;
    res.busy_res  = (phase_d != PH_IDLE);
    res.done_res  = done;
    res.presence  = pres_d;
    res.rx_byte   = rx_d;
    res.crc_value = crc_d;
    res.rejected  = rej;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rst_low_q    <= 10'd500;
      pres_delay_q <= 8'd30;
      pres_tail_q  <= 8'd240;
      slot_low_q   <= 4'd2;
      read_delay_q <= 6'd10;
      slot_len_q   <= 7'd60;
      recovery_q   <= 8'd2;
      phase_q      <= PH_IDLE;
      op_q         <= REQ_TICK;
      time_q       <= '0;
      bit_q        <= '0;
      shift_q      <= '0;
      pres_q       <= 1'b0;
      crc_q        <= '0;
      drive_q      <= 1'b0;
      rx_q         <= '0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
      out_q        <= '0;
      skid_q       <= '0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_idx_e'(cfg_index_i))
          CFG_RESET_LOW:  rst_low_q    <= cfg_data_i[9:0];
          CFG_PRES_DELAY: pres_delay_q <= cfg_data_i[7:0];
          CFG_PRES_TAIL:  pres_tail_q  <= cfg_data_i[7:0];
          CFG_SLOT_LOW:   slot_low_q   <= cfg_data_i[3:0];
          CFG_READ_DELAY: read_delay_q <= cfg_data_i[5:0];
          CFG_SLOT_LEN:   slot_len_q   <= cfg_data_i[6:0];
          CFG_RECOVERY:   recovery_q   <= cfg_data_i[7:0];
          default: begin
          end
        endcase
      end
      phase_q <= phase_d;
      op_q    <= op_d;
      time_q  <= time_d;
      bit_q   <= bit_d;
      shift_q <= shift_d;
      pres_q  <= pres_d;
      crc_q   <= crc_d;
      drive_q <= drive_d;
      rx_q    <= rx_d;
      if (out_free) begin
        if (skid_valid_q) begin
          out_q        <= skid_q;
          out_valid_q  <= 1'b1;
          skid_valid_q <= 1'b0;
        end else if (in_acc) begin
          out_q       <= res;
          out_valid_q <= 1'b1;
        end else begin
          out_valid_q <= 1'b0;
        end
      end else if (in_acc) begin
        skid_q       <= res;
        skid_valid_q <= 1'b1;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign drive_low_o = out_q.drive_low;
  assign busy_res_o  = out_q.busy_res;
  assign done_res_o  = out_q.done_res;
  assign presence_o  = out_q.presence;
  assign rx_byte_o   = out_q.rx_byte;
  assign crc_value_o = out_q.crc_value;
  assign rejected_o  = out_q.rejected;

endmodule

// File: rtl/owbm_checker.sv
// Port-level assertions for the one-wire bus master and their bind.
module owbm_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       drive_low_o,
  input logic       busy_res_o,
  input logic       done_res_o,
  input logic [7:0] rx_byte_o,
  input logic [7:0] crc_value_o,
  input logic       rejected_o
);

  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o |-> !busy_res_o)
    else $error("done word still shows busy");

  a_done_not_rejected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o |-> !rejected_o)
    else $error("word both finished and rejected");

  a_idle_released: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !busy_res_o |-> !drive_low_o)
    else $error("line driven low while idle");

  a_stall_needs_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no word pending");

  a_stalled_word_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(rx_byte_o) && $stable(crc_value_o))
    else $error("stalled result word changed");

endmodule

bind one_wire_bus_master_top owbm_checker u_owbm_checker (.*);
